### src/srr_pkg.sv
// Shared types and constants for the selective-repeat receiver.
// No dependencies; used by the top level, front end, queue, back end and testbench package.
`default_nettype none
package srr_pkg;

  localparam int SEQ_W    = 16;
  localparam int CHK_W    = 32;
  localparam int WIN_W    = 6;
  localparam int Q_DEPTH  = 2;
  localparam logic [WIN_W-1:0] WIN_RESET = 6'd8;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [31:0]      high;
    logic [63:0]      middle;
    logic [63:0]      low;
  } pkt_t;

  typedef struct packed {
    logic [31:0] high;
    logic [63:0] middle;
    logic [63:0] low;
  } data_t;

  typedef struct packed {
    logic  valid;
    data_t data;
  } slot_t;

  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } q_wr_t;

endpackage
`default_nettype wire

### src/srr_pkt_if.sv
// Packet input channel: valid/ready plus the packet fields.
// Standalone, no dependencies.
`default_nettype none
interface srr_pkt_if;
  logic        valid;
  logic        ready;
  logic [15:0] seq_number;
  logic [15:0] ack_number;
  logic signed [31:0] check_value;
  logic [63:0] payload_low;
  logic [63:0] payload_middle;
  logic [31:0] payload_high;

  modport source (output valid, seq_number, ack_number, check_value, payload_low,
                  payload_middle, payload_high, input ready);
  modport sink (input valid, seq_number, ack_number, check_value, payload_low,
                payload_middle, payload_high, output ready);
endinterface
`default_nettype wire

### src/srr_res_if.sv
// Result output channel: acks and delivered payloads.
// Standalone, no dependencies.
`default_nettype none
interface srr_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] ack_value;
  logic [15:0] ack_check;
  logic [63:0] out_low;
  logic [63:0] out_middle;
  logic [31:0] out_high;
  logic        last;

  modport source (output valid, kind, ack_value, ack_check, out_low, out_middle,
                  out_high, last, input ready);
  modport sink (input valid, kind, ack_value, ack_check, out_low, out_middle,
                out_high, last, output ready);
endinterface
`default_nettype wire

### src/srr_cfg_if.sv
// Configuration write channel for the window size register.
// Standalone, no dependencies.
`default_nettype none
interface srr_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### src/selective_repeat_receiver.sv
// Selective-repeat receiver top level: front end, packet queue, back end.
// A packet transfer is registered in the front-end stage and then pushed
// into the queue. The back end pops it; a packet outside the window is
// dropped without an ack, else its ack is sent and any in-order payloads are
// delivered, walking the ring one slot per cycle unless the output stalls.
// Reset: a clearing pass writes every ring slot; no packet transfer meanwhile.
`default_nettype none
module selective_repeat_receiver #(
  parameter int BUF_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  srr_cfg_if.sink    cfg,
  srr_pkt_if.sink    pkt_in,
  srr_res_if.source  res_out
);

  logic            hold;
  logic            q_full;
  srr_pkg::q_wr_t  q_wr;
  logic            q_valid;
  srr_pkg::pkt_t   q_data;
  logic            q_pop;

  srr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .hold   (hold),
    .pkt_in (pkt_in),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  srr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .pop      (q_pop)
  );

  srr_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .clearing (hold),
    .res_out  (res_out)
  );

endmodule
`default_nettype wire

### src/srr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/srr_front.sv
// Front end: takes packets, verifies the checksum over two stages and
// pushes good packets into the queue. Uses srr_pkg and srr_pkt_if.
`default_nettype none
module srr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          hold,
  srr_pkt_if.sink            pkt_in,
  input  wire logic          q_full,
  output srr_pkg::q_wr_t     q_wr
);

  logic               a_valid;
  srr_pkg::pkt_t      a_pkt;
  logic [15:0]        a_ack;
  logic [31:0]        a_check;
  logic signed [10:0] a_part [4];

  logic [159:0]       all_bytes;
  logic signed [12:0] bsum;
  logic [31:0]        total;
  logic               ok;
  logic               a_free;

  function automatic logic signed [10:0] grp_sum(input logic [39:0] b);
    logic signed [10:0] s;
    s = '0;
    for (int i = 0; i < 5; i++) begin
      s = s + {{3{b[8*i+7]}}, b[8*i +: 8]};
    end
    return s;
  endfunction

  assign all_bytes = {pkt_in.payload_high, pkt_in.payload_middle, pkt_in.payload_low};

  assign bsum = {{2{a_part[0][10]}}, a_part[0]} + {{2{a_part[1][10]}}, a_part[1]}
              + {{2{a_part[2][10]}}, a_part[2]} + {{2{a_part[3][10]}}, a_part[3]};
  assign total = {16'b0, a_pkt.seq} + {16'b0, a_ack} + {{19{bsum[12]}}, bsum};
  assign ok = (total == a_check);

  assign a_free = !a_valid || !ok || !q_full;
  assign pkt_in.ready = !hold && a_free;

  assign q_wr.valid = a_valid && ok;
  assign q_wr.pkt   = a_pkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= pkt_in.valid && pkt_in.ready;
    end
    if (pkt_in.valid && pkt_in.ready) begin
      a_pkt.seq    <= pkt_in.seq_number;
      a_pkt.low    <= pkt_in.payload_low;
      a_pkt.middle <= pkt_in.payload_middle;
      a_pkt.high   <= pkt_in.payload_high;
      a_ack        <= pkt_in.ack_number;
      a_check      <= $unsigned(pkt_in.check_value);
      for (int j = 0; j < 4; j++) begin
        a_part[j] <= grp_sum(all_bytes[40*j +: 40]);
      end
    end
  end

endmodule
`default_nettype wire

### src/srr_fifo.sv
// Short packet queue between front and back ends.
// Uses srr_pkg.
`default_nettype none
module srr_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire srr_pkg::q_wr_t wr,
  output logic                full,
  output logic                rd_valid,
  output srr_pkg::pkt_t       rd_data,
  input  wire logic           pop
);

  localparam int PW = (srr_pkg::Q_DEPTH > 1) ? $clog2(srr_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(srr_pkg::Q_DEPTH + 1);

  srr_pkg::pkt_t entry [srr_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(srr_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == CW'(srr_pkg::Q_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entry[rd_ptr];
  assign do_push  = wr.valid && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entry[wr_ptr] <= wr.pkt;
    end
  end

endmodule
`default_nettype wire

### src/srr_back.sv
// Back end: window check, ack generation, ring storage and in-order
// delivery. Uses srr_pkg, srr_ram, srr_cfg_if and srr_res_if.
`default_nettype none
module srr_back #(
  parameter int BUF_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  srr_cfg_if.sink            cfg,
  input  wire logic          q_valid,
  input  wire srr_pkg::pkt_t q_data,
  output logic               q_pop,
  output logic               clearing,
  srr_res_if.source          res_out
);

  localparam int AW   = $clog2(BUF_DEPTH);
  localparam int SW   = ((AW > srr_pkg::WIN_W) ? AW : srr_pkg::WIN_W) + 1;
  localparam int WMAX = (BUF_DEPTH - 1 < 63) ? BUF_DEPTH - 1 : 63;
  localparam int SLOT_W = $bits(srr_pkg::slot_t);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_ACK   = 4'b0100,
    S_CHECK = 4'b1000
  } state_t;

  state_t                     state;
  logic [srr_pkg::WIN_W-1:0]  win_cfg;
  logic [srr_pkg::WIN_W-1:0]  win;
  logic [15:0]                expected_seq;
  logic [AW-1:0]              head;
  logic [AW-1:0]              head_inc;
  logic [AW-1:0]              clr_addr;
  logic [srr_pkg::WIN_W-1:0]  k;
  logic [15:0]                cur_seq;
  srr_pkg::data_t             pend;
  logic                       is_exp;
  logic [srr_pkg::WIN_W-1:0]  ahead_off;
  logic [SW-1:0]              slot_sum;
  logic [AW-1:0]              ahead_slot;

  logic [15:0]                d;
  logic [15:0]                nd;
  logic                       in_win;
  logic                       more;
  logic                       out_free;
  logic                       res_load;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  srr_pkg::slot_t             ram_wdata;
  logic                       ram_re;
  srr_pkg::slot_t             ram_rdata;
  logic [SLOT_W-1:0]          ram_rvec;

  logic                       res_valid;
  logic                       res_kind;
  logic [15:0]                res_ack;
  srr_pkg::data_t             res_data;
  logic                       res_last;

  srr_ram #(.WIDTH(SLOT_W), .DEPTH(BUF_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_inc),
    .rdata (ram_rvec)
  );
  assign ram_rdata = ram_rvec;

  assign cfg.ready = 1'b1;
  assign clearing  = (state == S_CLEAR);

  always_comb begin
    if (win_cfg == '0) begin
      win = srr_pkg::WIN_W'(1);
    end else if (win_cfg > srr_pkg::WIN_W'(WMAX)) begin
      win = srr_pkg::WIN_W'(WMAX);
    end else begin
      win = win_cfg;
    end
  end

  assign head_inc = (head == AW'(BUF_DEPTH - 1)) ? '0 : head + 1'b1;
  assign d        = q_data.seq - expected_seq;
  assign nd       = 16'd0 - d;
  assign in_win   = (d < {10'b0, win}) || (nd <= {10'b0, win});
  assign more     = (k < win) && ram_rdata.valid;
  assign out_free = !res_valid || res_out.ready;
  assign res_load = out_free && ((state == S_ACK) || (state == S_CHECK));

  assign slot_sum   = SW'(head) + SW'(ahead_off);
  assign ahead_slot = (slot_sum >= SW'(BUF_DEPTH)) ? AW'(slot_sum - SW'(BUF_DEPTH))
                                                   : AW'(slot_sum);

  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head;
    ram_wdata = '0;
    ram_re    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_ACK: begin
        if (out_free) begin
          if (is_exp) begin
            ram_we = 1'b1;
            ram_re = 1'b1;
          end else if (ahead_off != '0) begin
            ram_we          = 1'b1;
            ram_waddr       = ahead_slot;
            ram_wdata.valid = 1'b1;
            ram_wdata.data  = pend;
          end
        end
      end
      S_CHECK: begin
        if (out_free && more) begin
          ram_we = 1'b1;
          ram_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      win_cfg      <= srr_pkg::WIN_RESET;
      expected_seq <= '0;
      head         <= '0;
      clr_addr     <= '0;
      k            <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        win_cfg <= cfg.data;
      end
      if (res_valid && res_out.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(BUF_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid && in_win) begin
            state <= S_ACK;
          end
        end
        S_ACK: begin
          if (out_free) begin
            res_valid <= 1'b1;
            if (is_exp) begin
              head         <= head_inc;
              expected_seq <= expected_seq + 1'b1;
              k            <= srr_pkg::WIN_W'(1);
              state        <= S_CHECK;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_CHECK: begin
          if (out_free) begin
            res_valid <= 1'b1;
            if (more) begin
              head         <= head_inc;
              expected_seq <= expected_seq + 1'b1;
              k            <= k + 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end

    if (q_pop) begin
      cur_seq   <= q_data.seq;
      pend      <= '{high: q_data.high, middle: q_data.middle, low: q_data.low};
      is_exp    <= (d == '0);
      ahead_off <= (d < {10'b0, win}) ? d[srr_pkg::WIN_W-1:0] : '0;
    end
    if (state == S_ACK && out_free) begin
      res_kind <= 1'b0;
      res_ack  <= cur_seq;
      res_data <= '0;
      res_last <= !is_exp;
    end
    if (state == S_CHECK && out_free) begin
      res_kind <= 1'b1;
      res_ack  <= '0;
      res_data <= pend;
      res_last <= !more;
      if (more) begin
        pend <= ram_rdata.data;
      end
    end
  end

  assign res_out.valid      = res_valid;
  assign res_out.kind       = res_kind;
  assign res_out.ack_value  = res_ack;
  assign res_out.ack_check  = res_ack;
  assign res_out.out_low    = res_data.low;
  assign res_out.out_middle = res_data.middle;
  assign res_out.out_high   = res_data.high;
  assign res_out.last       = res_last;

endmodule
`default_nettype wire

### verif/srr_tb_pkg.sv
// Testbench types, checksum helper and the delivery scoreboard for the
// selective-repeat receiver. Depends on srr_pkg.
`default_nettype none
package srr_tb_pkg;
  import srr_pkg::*;

  localparam int RING_DEPTH = 64;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_DATA = 1'b1
  } kind_e;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] ack;
    logic [31:0] chk;
    logic [63:0] low;
    logic [63:0] middle;
    logic [31:0] high;
  } packet_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] ack_value;
    logic [15:0] ack_check;
    logic [63:0] out_low;
    logic [63:0] out_middle;
    logic [31:0] out_high;
    logic        last;
  } result_t;

  function automatic logic [31:0] packet_sum(logic [15:0] seq, logic [15:0] ack,
                                             logic [63:0] lo, logic [63:0] mid,
                                             logic [31:0] hi);
    logic [31:0] acc;
    acc = 32'(seq) + 32'(ack);
    for (int i = 0; i < 8; i++) begin
      acc += {{24{lo[8*i+7]}}, lo[8*i +: 8]};
      acc += {{24{mid[8*i+7]}}, mid[8*i +: 8]};
    end
    for (int i = 0; i < 4; i++) acc += {{24{hi[8*i+7]}}, hi[8*i +: 8]};
    return acc;
  endfunction

  class delivery_scoreboard;
    logic [15:0] next_seq;
    int unsigned head;
    logic [5:0]  window;
    bit          slot_full[RING_DEPTH];
    data_t       ring[RING_DEPTH];
    result_t     expected_out[$];
    int unsigned errors;

    function new();
      next_seq = '0;
      head = 0;
      window = WIN_RESET;
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      errors = 0;
    endfunction

    function void set_window(logic [5:0] value);
      window = value;
    endfunction

    function int unsigned span();
      int unsigned w;
      w = (window == 0) ? 1 : int'(window);
      if (w > RING_DEPTH - 1) w = RING_DEPTH - 1;
      return w;
    endfunction

    function int unsigned pending();
      return expected_out.size();
    endfunction

    function void note_packet(packet_t p);
      int unsigned w;
      int unsigned slot;
      logic [15:0] offset;
      result_t r;
      if (packet_sum(p.seq, p.ack, p.low, p.middle, p.high) != p.chk) return;
      w = span();
      offset = p.seq - next_seq;
      if (!(offset < w || int'(offset) >= 65536 - w)) return;
      r = '0;
      r.kind = KIND_ACK;
      r.ack_value = p.seq;
      r.ack_check = p.seq;
      expected_out.push_back(r);
      if (offset == 0) begin
        r = '0;
        r.kind = KIND_DATA;
        r.out_low = p.low;
        r.out_middle = p.middle;
        r.out_high = p.high;
        expected_out.push_back(r);
        slot_full[head] = 1'b0;
        head = (head + 1) % RING_DEPTH;
        next_seq = next_seq + 16'd1;
        for (int k = 1; k < w; k++) begin
          if (!slot_full[head]) break;
          r = '0;
          r.kind = KIND_DATA;
          r.out_low = ring[head].low;
          r.out_middle = ring[head].middle;
          r.out_high = ring[head].high;
          expected_out.push_back(r);
          slot_full[head] = 1'b0;
          head = (head + 1) % RING_DEPTH;
          next_seq = next_seq + 16'd1;
        end
      end else if (offset < w) begin
        slot = (head + int'(offset)) % RING_DEPTH;
        ring[slot].low = p.low;
        ring[slot].middle = p.middle;
        ring[slot].high = p.high;
        slot_full[slot] = 1'b1;
      end
      expected_out[expected_out.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s expected %h actual %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_out.size() == 0) begin
        $error("result transfer with nothing expected: kind %0d ack_value %h",
               got.kind, got.ack_value);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      compare_field("kind", 64'(want.kind), 64'(got.kind));
      compare_field("ack_value", 64'(want.ack_value), 64'(got.ack_value));
      compare_field("ack_check", 64'(want.ack_check), 64'(got.ack_check));
      compare_field("out_low", want.out_low, got.out_low);
      compare_field("out_middle", want.out_middle, got.out_middle);
      compare_field("out_high", 64'(want.out_high), 64'(got.out_high));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

endpackage
`default_nettype wire

### verif/tb.sv
// Testbench top for selective_repeat_receiver: directed and random packet
// streams with random idling, checked against delivery_scoreboard.
// Depends on srr_pkg, the srr_*_if interfaces and srr_tb_pkg.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srr_pkg::*;
  import srr_tb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef enum int {PAY_ZERO, PAY_ONES, PAY_MIN, PAY_MAX, PAY_RAND} payload_e;
  typedef enum int {NOISE_BAD_SUM, NOISE_OLD, NOISE_BEYOND, NOISE_ANY, NOISE_REPEAT} noise_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit quiet = 1'b0;
  int unsigned idle_cycles = 0;
  delivery_scoreboard sb;

  srr_cfg_if cfg_bus();
  srr_pkt_if pkt_bus();
  srr_res_if res_bus();

  selective_repeat_receiver uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .pkt_in (pkt_bus),
    .res_out(res_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic payload_e pick_payload();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return payload_e'(r);
    return PAY_RAND;
  endfunction

  function automatic packet_t make_packet(logic [15:0] seq, bit good, payload_e pay);
    packet_t p;
    logic [31:0] flip;
    p.seq = seq;
    case (pay)
      PAY_ZERO: begin p.ack = 16'h0000; p.low = '0; p.middle = '0; p.high = '0; end
      PAY_ONES: begin p.ack = 16'hFFFF; p.low = '1; p.middle = '1; p.high = '1; end
      PAY_MIN: begin
        p.ack = 16'($urandom);
        p.low = {8{8'h80}}; p.middle = {8{8'h80}}; p.high = {4{8'h80}};
      end
      PAY_MAX: begin
        p.ack = 16'($urandom);
        p.low = {8{8'h7F}}; p.middle = {8{8'h7F}}; p.high = {4{8'h7F}};
      end
      default: begin
        p.ack = 16'($urandom);
        p.low = {$urandom, $urandom};
        p.middle = {$urandom, $urandom};
        p.high = $urandom;
      end
    endcase
    p.chk = packet_sum(p.seq, p.ack, p.low, p.middle, p.high);
    if (!good) begin
      flip = $urandom;
      if (flip == 0) flip = 32'h1;
      p.chk = p.chk ^ flip;
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if ((pkt_bus.valid && pkt_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    result_t got;
    stall = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_bus.valid && res_bus.ready) begin
        got.kind = kind_e'(res_bus.kind);
        got.ack_value = res_bus.ack_value;
        got.ack_check = res_bus.ack_check;
        got.out_low = res_bus.out_low;
        got.out_middle = res_bus.out_middle;
        got.out_high = res_bus.out_high;
        got.last = res_bus.last;
        sb.check_result(got);
      end
      if (stall != 0) begin
        stall--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
        stall = idle_len();
      end
    end
  end

  task automatic send_packet(packet_t p);
    int unsigned gap;
    pkt_bus.valid <= 1'b1;
    pkt_bus.seq_number <= p.seq;
    pkt_bus.ack_number <= p.ack;
    pkt_bus.check_value <= p.chk;
    pkt_bus.payload_low <= p.low;
    pkt_bus.payload_middle <= p.middle;
    pkt_bus.payload_high <= p.high;
    do @(posedge clk); while (!pkt_bus.ready);
    sb.note_packet(p);
    gap = idle_len();
    if (gap != 0) begin
      pkt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    pkt_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [5:0] value);
    wait_idle();
    cfg_bus.data <= value;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    sb.set_window(value);
  endtask

  task automatic send_noise(int unsigned w);
    noise_e pick;
    logic [15:0] s;
    bit good;
    pick = noise_e'($urandom_range(0, 4));
    good = 1'b1;
    case (pick)
      NOISE_BAD_SUM: begin
        s = sb.next_seq + 16'($urandom_range(0, w - 1));
        good = 1'b0;
      end
      NOISE_OLD: s = sb.next_seq - 16'($urandom_range(1, w));
      NOISE_BEYOND: s = sb.next_seq + 16'(w) + 16'($urandom_range(0, 2000));
      NOISE_ANY: s = 16'($urandom);
      default: s = sb.next_seq + 16'($urandom_range(0, w - 1));
    endcase
    send_packet(make_packet(s, good, pick_payload()));
  endtask

  task automatic run_phase(logic [5:0] setting, int unsigned budget, bit calm);
    int unsigned w;
    int unsigned len;
    int unsigned count;
    int unsigned j;
    int unsigned t;
    int unsigned offs[$];
    logic [15:0] base;
    bit full_burst;
    write_window(setting);
    quiet = calm;
    w = sb.span();
    count = 0;
    while (count < budget) begin
      full_burst = (count == 0) && (w == RING_DEPTH - 1);
      len = full_burst ? w : $urandom_range(1, w);
      base = sb.next_seq;
      offs.delete();
      for (int i = 0; i < len; i++) offs.push_back(i);
      if (full_burst || $urandom_range(0, 3) == 0) begin
        offs.reverse();
      end else begin
        for (int i = len - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = offs[i];
          offs[i] = offs[j];
          offs[j] = t;
        end
      end
      foreach (offs[i]) begin
        if (!full_burst && $urandom_range(0, 4) == 0) send_noise(w);
        send_packet(make_packet(base + 16'(offs[i]), 1'b1, pick_payload()));
        count++;
      end
    end
    quiet = 1'b0;
  endtask

  task automatic run_directed();
    packet_t p;
    write_window(6'd8);
    send_packet(make_packet(16'd0, 1'b1, PAY_ZERO));
    send_packet(make_packet(16'd1, 1'b1, PAY_ONES));
    send_packet(make_packet(16'd3, 1'b1, PAY_MIN));
    send_packet(make_packet(16'd2, 1'b1, PAY_MAX));
    send_packet(make_packet(16'd4, 1'b0, PAY_RAND));
    p = make_packet(16'd4, 1'b1, PAY_ZERO);
    p.chk = 32'h8000_0000;
    send_packet(p);
    p.chk = 32'h7FFF_FFFF;
    send_packet(p);
    // old, window edges on both sides, one past each edge
    send_packet(make_packet(16'd2, 1'b1, PAY_RAND));
    send_packet(make_packet(16'd12, 1'b1, PAY_RAND));
    send_packet(make_packet(16'd11, 1'b1, PAY_RAND));
    send_packet(make_packet(16'hFFFC, 1'b1, PAY_RAND));
    send_packet(make_packet(16'hFFFB, 1'b1, PAY_RAND));
    send_packet(make_packet(16'hFFFF, 1'b1, PAY_ONES));
    // duplicate ahead packet overwrites the stored copy
    send_packet(make_packet(16'd5, 1'b1, PAY_RAND));
    send_packet(make_packet(16'd5, 1'b1, PAY_RAND));
    send_packet(make_packet(16'd4, 1'b1, PAY_RAND));
  endtask

  initial begin
    sb = new();
    cfg_bus.valid <= 1'b0;
    cfg_bus.data <= '0;
    pkt_bus.valid <= 1'b0;
    pkt_bus.seq_number <= '0;
    pkt_bus.ack_number <= '0;
    pkt_bus.check_value <= '0;
    pkt_bus.payload_low <= '0;
    pkt_bus.payload_middle <= '0;
    pkt_bus.payload_high <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_phase(6'd1, 25, 1'b0);
    run_phase(6'd63, 63, 1'b0);
    run_phase(6'd0, 20, 1'b1);
    run_phase(6'($urandom_range(2, 62)), 30, 1'b0);
    run_phase(6'd8, 25, 1'b0);
    run_phase(6'd63, 20, 1'b1);
    pkt_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
